### design/scc_pkg.sv
// Shared types for the segment and circle collision pipeline.
// No dependencies; used by scc_test and segment_circle_collision.
package scc_pkg;

   typedef enum logic [1:0] {
      KIND_NONE     = 2'd0,
      KIND_ENDPOINT = 2'd1,
      KIND_INTERIOR = 2'd2
   } contact_kind_type;

endpackage

### design/segment_circle_collision.sv
// Segment against circle collision test. Each transaction carries a circle and a
// segment; the block answers endpoint-inside (strict) or interior-within-radius,
// the latter tested exactly as cross^2 <= r^2*len2 with the projection bound
// 0 <= dot <= len2 for a nonzero len2. The pipeline has seven register stages and
// accepts a transaction every cycle unless back-pressure fills it; throughput is
// one test per clock while rsp_ready keeps up, set by the fully pipelined multiplier
// stages. A stalled result does not block intake until all seven stages are full.
// Depends on scc_pkg, scc_front and scc_test.
module segment_circle_collision #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_circle_x,
   input  logic signed [COORD_WIDTH-1:0] req_circle_y,
   input  logic [COORD_WIDTH-2:0]        req_circle_radius,
   input  logic signed [COORD_WIDTH-1:0] req_seg_ax,
   input  logic signed [COORD_WIDTH-1:0] req_seg_ay,
   input  logic signed [COORD_WIDTH-1:0] req_seg_bx,
   input  logic signed [COORD_WIDTH-1:0] req_seg_by,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output scc_pkg::contact_kind_type     rsp_contact_kind
);

   localparam int LW  = 2 * COORD_WIDTH + 1;
   localparam int PW  = 2 * COORD_WIDTH + 2;
   localparam int R2W = 2 * COORD_WIDTH - 2;

   logic                 mid_valid, mid_ready;
   logic [LW-1:0]        mid_da2, mid_db2, mid_len2;
   logic signed [PW-1:0] mid_dot, mid_cross;
   logic [R2W-1:0]       mid_r2;

   scc_front #(
      .W (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .cx         (req_circle_x),
      .cy         (req_circle_y),
      .rad        (req_circle_radius),
      .ax         (req_seg_ax),
      .ay         (req_seg_ay),
      .bx         (req_seg_bx),
      .by         (req_seg_by),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .da2        (mid_da2),
      .db2        (mid_db2),
      .len2       (mid_len2),
      .dot        (mid_dot),
      .cross_prod (mid_cross),
      .r2         (mid_r2)
   );

   scc_test #(
      .W (COORD_WIDTH)
   ) u_test (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (mid_valid),
      .in_ready     (mid_ready),
      .da2          (mid_da2),
      .db2          (mid_db2),
      .len2         (mid_len2),
      .dot          (mid_dot),
      .cross_prod   (mid_cross),
      .r2           (mid_r2),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .hit          (rsp_hit),
      .contact_kind (rsp_contact_kind)
   );

endmodule

### design/scc_front.sv
// Front half of the collision pipeline: coordinate differences, signed products
// and their sums. Three register stages; no package dependencies.
module scc_front #(
   parameter int W = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [W-1:0] cx,
   input  logic signed [W-1:0] cy,
   input  logic [W-2:0]        rad,
   input  logic signed [W-1:0] ax,
   input  logic signed [W-1:0] ay,
   input  logic signed [W-1:0] bx,
   input  logic signed [W-1:0] by,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [2*W:0]        da2,
   output logic [2*W:0]        db2,
   output logic [2*W:0]        len2,
   output logic signed [2*W+1:0] dot,
   output logic signed [2*W+1:0] cross_prod,
   output logic [2*W-3:0]      r2
);

   localparam int DW   = W + 1;
   localparam int PW   = 2 * W + 2;
   localparam int SW   = 2 * W;
   localparam int LW   = 2 * W + 1;
   localparam int R2W  = 2 * W - 2;
   localparam int NSTG = 3;

   logic [NSTG-1:0] vld_ff, vld_in, stage_en;

   // Stage 1: differences.
   logic signed [DW-1:0] dax_ff, day_ff, dbx_ff, dby_ff, ex_ff, ey_ff;
   logic signed [DW-1:0] dax_in, day_in, dbx_in, dby_in, ex_in, ey_in;
   logic [W-2:0]         rad_ff;

   // Stage 2: products.
   logic signed [PW-1:0] pxex_ff, pyey_ff, pxey_ff, pyex_ff;
   logic signed [PW-1:0] pxex_in, pyey_in, pxey_in, pyex_in;
   logic signed [PW-1:0] sqax_full, sqay_full, sqbx_full, sqby_full, sqex_full, sqey_full;
   logic [SW-1:0]        sqax_ff, sqay_ff, sqbx_ff, sqby_ff, sqex_ff, sqey_ff;
   logic [R2W-1:0]       r2s2_ff, r2s2_in;

   // Stage 3: sums.
   logic [LW-1:0]        da2_ff, db2_ff, len2_ff, da2_in, db2_in, len2_in;
   logic signed [PW-1:0] dot_ff, cross_ff, dot_in, cross_in;
   logic [R2W-1:0]       r2s3_ff;

   always_comb begin
      stage_en[NSTG-1] = !vld_ff[NSTG-1] || out_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      vld_in[0] = stage_en[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = stage_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      dax_in = $signed({cx[W-1], cx}) - $signed({ax[W-1], ax});
      day_in = $signed({cy[W-1], cy}) - $signed({ay[W-1], ay});
      dbx_in = $signed({cx[W-1], cx}) - $signed({bx[W-1], bx});
      dby_in = $signed({cy[W-1], cy}) - $signed({by[W-1], by});
      ex_in  = $signed({bx[W-1], bx}) - $signed({ax[W-1], ax});
      ey_in  = $signed({by[W-1], by}) - $signed({ay[W-1], ay});
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dax_ff <= dax_in;
         day_ff <= day_in;
         dbx_ff <= dbx_in;
         dby_ff <= dby_in;
         ex_ff  <= ex_in;
         ey_ff  <= ey_in;
         rad_ff <= rad;
      end
   end

   // A difference magnitude stays below 2**W, so every square fits in 2*W bits.
   always_comb begin
      sqax_full = dax_ff * dax_ff;
      sqay_full = day_ff * day_ff;
      sqbx_full = dbx_ff * dbx_ff;
      sqby_full = dby_ff * dby_ff;
      sqex_full = ex_ff * ex_ff;
      sqey_full = ey_ff * ey_ff;
      pxex_in   = dax_ff * ex_ff;
      pyey_in   = day_ff * ey_ff;
      pxey_in   = dax_ff * ey_ff;
      pyex_in   = day_ff * ex_ff;
      r2s2_in   = rad_ff * rad_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         sqax_ff <= sqax_full[SW-1:0];
         sqay_ff <= sqay_full[SW-1:0];
         sqbx_ff <= sqbx_full[SW-1:0];
         sqby_ff <= sqby_full[SW-1:0];
         sqex_ff <= sqex_full[SW-1:0];
         sqey_ff <= sqey_full[SW-1:0];
         pxex_ff <= pxex_in;
         pyey_ff <= pyey_in;
         pxey_ff <= pxey_in;
         pyex_ff <= pyex_in;
         r2s2_ff <= r2s2_in;
      end
   end

   always_comb begin
      da2_in   = LW'(sqax_ff) + LW'(sqay_ff);
      db2_in   = LW'(sqbx_ff) + LW'(sqby_ff);
      len2_in  = LW'(sqex_ff) + LW'(sqey_ff);
      dot_in   = pxex_ff + pyey_ff;
      cross_in = pxey_ff - pyex_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         da2_ff   <= da2_in;
         db2_ff   <= db2_in;
         len2_ff  <= len2_in;
         dot_ff   <= dot_in;
         cross_ff <= cross_in;
         r2s3_ff  <= r2s2_ff;
      end
   end

   assign in_ready   = stage_en[0];
   assign out_valid  = vld_ff[NSTG-1];
   assign da2        = da2_ff;
   assign db2        = db2_ff;
   assign len2       = len2_ff;
   assign dot        = dot_ff;
   assign cross_prod = cross_ff;
   assign r2         = r2s3_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> vld_ff[0])
      else $error("Accepted transaction did not enter the first stage.");

   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && len2_ff == '0) |-> (dot_ff == '0 && cross_ff == '0))
      else $error("Zero-length segment produced a nonzero dot or cross product.");

   a_hold_sums: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && !stage_en[2]) |=> ($stable(dot_ff) && $stable(cross_ff)))
      else $error("Stalled sum stage changed its contents.");

endmodule

### design/scc_test.sv
// Back half of the collision pipeline: endpoint and projection tests, split
// products for cross^2 and r^2*len2, final compare. Uses scc_pkg.
module scc_test #(
   parameter int W = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [2*W:0]                 da2,
   input  logic [2*W:0]                 db2,
   input  logic [2*W:0]                 len2,
   input  logic signed [2*W+1:0]        dot,
   input  logic signed [2*W+1:0]        cross_prod,
   input  logic [2*W-3:0]               r2,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic                         hit,
   output scc_pkg::contact_kind_type    contact_kind
);

   localparam int PW   = 2 * W + 2;
   localparam int LW   = 2 * W + 1;
   localparam int R2W  = 2 * W - 2;
   localparam int QW   = 4 * W + 2;
   localparam int NSTG = 4;

   logic [NSTG-1:0] vld_ff, vld_in, stage_en;

   // Stage 4: flags and cross magnitude.
   logic                 inside4_ff, onseg4_ff, inside4_in, onseg4_in;
   logic [LW-1:0]        acr_ff, acr_in, len2_4_ff;
   logic signed [PW-1:0] neg_cross;
   logic [R2W-1:0]       r2_4_ff;

   // Stage 5: partial products.
   logic [W-1:0]   ch, lh;
   logic [W:0]     cl, ll;
   logic [W-2:0]   rh, rl;
   logic [2*W-1:0] hh_ff, hh_in, rhl_ff, rhl_in, rll_ff, rll_in;
   logic [2*W:0]   hl_ff, hl_in;
   logic [2*W+1:0] cll_ff, cll_in;
   logic [2*W-2:0] rhh_ff, rhh_in, rlh_ff, rlh_in;
   logic           inside5_ff, onseg5_ff;

   // Stage 6: assembled squares.
   logic [QW-1:0]  c2_ff, c2_in, rlen_ff, rlen_in;
   logic           inside6_ff, onseg6_ff;

   // Stage 7: result register.
   logic                       interior;
   logic                       hit_ff, hit_in;
   scc_pkg::contact_kind_type  kind_ff, kind_in;

   always_comb begin
      stage_en[NSTG-1] = !vld_ff[NSTG-1] || out_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      vld_in[0] = stage_en[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = stage_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // The projection lies on the segment when len2 is nonzero and 0 <= dot <= len2.
   always_comb begin
      inside4_in = (da2 < LW'(r2)) || (db2 < LW'(r2));
      onseg4_in  = (len2 != '0) && !dot[PW-1] && (dot <= $signed({1'b0, len2}));
      neg_cross  = -cross_prod;
      acr_in     = cross_prod[PW-1] ? neg_cross[LW-1:0] : cross_prod[LW-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         inside4_ff <= inside4_in;
         onseg4_ff  <= onseg4_in;
         acr_ff     <= acr_in;
         len2_4_ff  <= len2;
         r2_4_ff    <= r2;
      end
   end

   // Split the wide operands so that no multiplier exceeds W+1 bits a side.
   always_comb begin
      cl     = acr_ff[W:0];
      ch     = acr_ff[2*W:W+1];
      ll     = len2_4_ff[W:0];
      lh     = len2_4_ff[2*W:W+1];
      rl     = r2_4_ff[W-2:0];
      rh     = r2_4_ff[2*W-3:W-1];
      hh_in  = ch * ch;
      hl_in  = ch * cl;
      cll_in = cl * cl;
      rhh_in = rh * lh;
      rhl_in = rh * ll;
      rlh_in = rl * lh;
      rll_in = rl * ll;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         hh_ff      <= hh_in;
         hl_ff      <= hl_in;
         cll_ff     <= cll_in;
         rhh_ff     <= rhh_in;
         rhl_ff     <= rhl_in;
         rlh_ff     <= rlh_in;
         rll_ff     <= rll_in;
         inside5_ff <= inside4_ff;
         onseg5_ff  <= onseg4_ff;
      end
   end

   // The cross term appears twice in the square, hence the extra bit of shift.
   always_comb begin
      c2_in   = (QW'(hh_ff) << (2 * W + 2)) + (QW'(hl_ff) << (W + 2)) + QW'(cll_ff);
      rlen_in = (QW'(rhh_ff) << (2 * W)) + (QW'(rhl_ff) << (W - 1))
              + (QW'(rlh_ff) << (W + 1)) + QW'(rll_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         c2_ff      <= c2_in;
         rlen_ff    <= rlen_in;
         inside6_ff <= inside5_ff;
         onseg6_ff  <= onseg5_ff;
      end
   end

   always_comb begin
      interior = onseg6_ff && (c2_ff <= rlen_ff);
      hit_in   = inside6_ff || interior;
      if (inside6_ff) begin
         kind_in = scc_pkg::KIND_ENDPOINT;
      end else if (interior) begin
         kind_in = scc_pkg::KIND_INTERIOR;
      end else begin
         kind_in = scc_pkg::KIND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         hit_ff  <= hit_in;
         kind_ff <= kind_in;
      end
   end

   assign in_ready     = stage_en[0];
   assign out_valid    = vld_ff[NSTG-1];
   assign hit          = hit_ff;
   assign contact_kind = kind_ff;

   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (hit_ff == (kind_ff != scc_pkg::KIND_NONE)))
      else $error("Hit flag disagrees with contact kind.");

   a_interior_needs_len: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && onseg4_ff) |-> (len2_4_ff != '0))
      else $error("Projection flag set for a zero-length segment.");

   a_hold_squares: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && !stage_en[2]) |=> ($stable(c2_ff) && $stable(rlen_ff)))
      else $error("Stalled square stage changed its contents.");

endmodule
